FILE: hw/rtl/clipped_rect_fill_blend_assert.svh
// assertion macros shared by the clipped rectangle fill and blend block
`ifndef CLIPPED_RECT_FILL_BLEND_ASSERT_SVH
`define CLIPPED_RECT_FILL_BLEND_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define CRFB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define CRFB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CRFB_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define CRFB_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/crfb_pkg.sv
// types and constants for the clipped rectangle fill and blend block
`timescale 1ns / 1ps
package crfb_pkg;

   localparam int ROW_PIXELS  = 240;
   localparam int ROW_COUNT   = 400;
   localparam int STORE_DEPTH = ROW_PIXELS * ROW_COUNT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int COL_W       = $clog2(ROW_PIXELS + 1);
   localparam int ROW_W       = $clog2(ROW_COUNT + 1);
   localparam int CH_W        = 8;
   localparam int CH_COUNT    = 3;
   localparam int PIX_W       = CH_W * CH_COUNT;
   localparam int TOUCH_W     = 17;

   localparam logic CMD_FILL = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [CH_W-1:0] ALPHA_CLEAR  = 8'h00;

   typedef struct packed {
      logic               cmd;
      logic signed [15:0] origin_col;
      logic signed [15:0] origin_row;
      logic [15:0]        span_cols;
      logic [15:0]        span_rows;
      logic [CH_W-1:0]    fill_red;
      logic [CH_W-1:0]    fill_green;
      logic [CH_W-1:0]    fill_blue;
      logic [CH_W-1:0]    fill_alpha;
   } req_word_type;

   typedef struct packed {
      logic [CH_W-1:0]    pixel_red;
      logic [CH_W-1:0]    pixel_green;
      logic [CH_W-1:0]    pixel_blue;
      logic [TOUCH_W-1:0] pixels_touched;
      logic               outside_flag;
   } rsp_word_type;

   typedef struct packed {
      logic capture;
      logic setup;
      logic start;
      logic clr_step;
      logic pix_write;
      logic mem_read;
      logic bl_mult;
      logic bl_write;
      logic rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic is_read;
      logic rd_outside;
      logic reject;
      logic empty;
      logic opaque;
      logic last_pixel;
   } dp_stat_type;

   typedef enum logic [9:0] {
      ST_CLEAR    = 10'b00_0000_0001,
      ST_IDLE     = 10'b00_0000_0010,
      ST_SETUP    = 10'b00_0000_0100,
      ST_START    = 10'b00_0000_1000,
      ST_RD_ISSUE = 10'b00_0001_0000,
      ST_FILL_WR  = 10'b00_0010_0000,
      ST_BL_READ  = 10'b00_0100_0000,
      ST_BL_MULT  = 10'b00_1000_0000,
      ST_BL_WRITE = 10'b01_0000_0000,
      ST_FINISH   = 10'b10_0000_0000
   } state_type;

endpackage

FILE: hw/rtl/clipped_rect_fill_blend.sv
// clipped rectangle fill with alpha blend over a 24-bit frame store, top level
//
//   channel | ports                      | word
//   --------+----------------------------+------------------------------------
//   request | req_valid req_stall        | req_word  command, rectangle, color
//   result  | rsp_valid rsp_stall        | rsp_word  pixel, touched count, flag
//
// after reset a clearing pass writes black to all ROW_PIXELS*ROW_COUNT (96000) entries,
// one per cycle, and no request word is taken until it ends
// read: setup, start, a frame store read unless outside, finish; rejected, empty or
// transparent fill: setup, start, finish; opaque fill adds one write per clipped pixel;
// blended fill adds a read, multiply and write-back per pixel on the single frame store port
// a finished result word is held in its register while rsp_stall is high;
// the next request word is taken meanwhile and waits at its end for the slot
`timescale 1ns / 1ps
module clipped_rect_fill_blend (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  crfb_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output crfb_pkg::rsp_word_type rsp_word
);
   import crfb_pkg::*;

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   crfb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat_i    (dp_stat),
      .cmd_o     (dp_cmd)
   );

   crfb_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .cmd_i    (dp_cmd),
      .stat_o   (dp_stat),
      .rsp_word (rsp_word)
   );

endmodule

FILE: hw/rtl/crfb_datapath.sv
// clipping, sweep counters, frame store and blend arithmetic
`timescale 1ns / 1ps
`include "clipped_rect_fill_blend_assert.svh"
module crfb_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  crfb_pkg::req_word_type req_word,
   input  crfb_pkg::dp_cmd_type  cmd_i,
   output crfb_pkg::dp_stat_type stat_o,
   output crfb_pkg::rsp_word_type rsp_word
);
   import crfb_pkg::*;

   req_word_type       req_ff, req_in;
   rsp_word_type       rsp_ff, rsp_in;
   logic [COL_W-1:0]   c0_ff, c0_in, c_end_ff, c_end_in, col_ff, col_in, col_nxt;
   logic [ROW_W-1:0]   r0_ff, r0_in, r_end_ff, r_end_in, row_ff, row_in, row_nxt;
   logic               reject_ff, reject_in, rd_out_ff, rd_out_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in, row_base_ff, row_base_in;
   logic [ADDR_W-1:0]  start_addr, row_base_nxt;
   logic [TOUCH_W-1:0] touched_ff, touched_in;
   logic [PIX_W-1:0]   rdata_ff;
   logic [15:0]        fg_ff [CH_COUNT];
   logic [15:0]        fg_in [CH_COUNT];
   logic [15:0]        bg_ff [CH_COUNT];
   logic [15:0]        bg_in [CH_COUNT];
   logic [16:0]        mix_sum [CH_COUNT];
   logic [16:0]        mix_adj [CH_COUNT];
   logic [PIX_W-1:0]   mem [STORE_DEPTH];
   logic [PIX_W-1:0]   color_v, blend_v, wdata;
   logic               mem_we, advance, last_col, is_read;
   logic signed [15:0] s_col, s_row;
   logic signed [17:0] col_sum, row_sum;
   logic [CH_W-1:0]    inv_alpha;

   assign s_col   = req_ff.origin_col;
   assign s_row   = req_ff.origin_row;
   assign col_sum = 18'(s_col) + $signed({2'b00, req_ff.span_cols});
   assign row_sum = 18'(s_row) + $signed({2'b00, req_ff.span_rows});
   assign is_read = (req_ff.cmd == CMD_READ);

   assign color_v   = {req_ff.fill_red, req_ff.fill_green, req_ff.fill_blue};
   assign inv_alpha = ALPHA_OPAQUE - req_ff.fill_alpha;

   assign col_nxt      = col_ff + COL_W'(1);
   assign row_nxt      = row_ff + ROW_W'(1);
   assign last_col     = (col_nxt == c_end_ff);
   assign row_base_nxt = row_base_ff + ADDR_W'(ROW_PIXELS);
   assign start_addr   = ADDR_W'(r0_ff * ROW_PIXELS) + ADDR_W'(c0_ff);
   assign advance      = cmd_i.pix_write | cmd_i.bl_write;
   assign mem_we       = cmd_i.clr_step | advance;

   // divide by 255 as (x + 1 + (x >> 8)) >> 8, exact up to 255*255
   always_comb begin
      for (int i = 0; i < CH_COUNT; i++) begin
         mix_sum[i] = 17'(fg_ff[i]) + 17'(bg_ff[i]);
         mix_adj[i] = mix_sum[i] + 17'd1 + 17'(mix_sum[i][16:8]);
         blend_v[CH_W*i +: CH_W] = mix_adj[i][15:8];
      end
   end

   always_comb begin
      if (cmd_i.clr_step) begin
         wdata = '0;
      end else if (cmd_i.pix_write) begin
         wdata = color_v;
      end else begin
         wdata = blend_v;
      end
   end

   always_comb begin
      for (int i = 0; i < CH_COUNT; i++) begin
         fg_in[i] = fg_ff[i];
         bg_in[i] = bg_ff[i];
         if (cmd_i.bl_mult) begin
            fg_in[i] = 16'(req_ff.fill_alpha) * 16'(color_v[CH_W*i +: CH_W]);
            bg_in[i] = 16'(inv_alpha) * 16'(rdata_ff[CH_W*i +: CH_W]);
         end
      end
   end

   always_comb begin
      req_in      = req_ff;
      c0_in       = c0_ff;
      c_end_in    = c_end_ff;
      r0_in       = r0_ff;
      r_end_in    = r_end_ff;
      reject_in   = reject_ff;
      rd_out_in   = rd_out_ff;
      addr_in     = addr_ff;
      row_base_in = row_base_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      touched_in  = touched_ff;
      rsp_in      = rsp_ff;
      if (cmd_i.capture) begin
         req_in = req_word;
      end
      if (cmd_i.setup) begin
         c0_in     = (s_col < 0) ? '0 : s_col[COL_W-1:0];
         r0_in     = (s_row < 0) ? '0 : s_row[ROW_W-1:0];
         c_end_in  = (col_sum >= ROW_PIXELS) ? COL_W'(ROW_PIXELS) : col_sum[COL_W-1:0];
         r_end_in  = (row_sum >= ROW_COUNT) ? ROW_W'(ROW_COUNT) : row_sum[ROW_W-1:0];
         reject_in = (col_sum < 0) || (s_col >= ROW_PIXELS) ||
                     (row_sum < 0) || (s_row >= ROW_COUNT);
         rd_out_in = (s_col < 0) || (s_col >= ROW_PIXELS) ||
                     (s_row < 0) || (s_row >= ROW_COUNT);
      end
      if (cmd_i.start) begin
         addr_in     = start_addr;
         row_base_in = start_addr;
         col_in      = c0_ff;
         row_in      = r0_ff;
         touched_in  = '0;
      end
      if (cmd_i.clr_step) begin
         addr_in = addr_ff + ADDR_W'(1);
      end
      if (advance) begin
         touched_in = touched_ff + TOUCH_W'(1);
         if (last_col) begin
            col_in      = c0_ff;
            row_in      = row_nxt;
            row_base_in = row_base_nxt;
            addr_in     = row_base_nxt;
         end else begin
            col_in  = col_nxt;
            addr_in = addr_ff + ADDR_W'(1);
         end
      end
      if (cmd_i.rsp_load) begin
         if (is_read && !rd_out_ff) begin
            rsp_in.pixel_red   = rdata_ff[2*CH_W +: CH_W];
            rsp_in.pixel_green = rdata_ff[CH_W +: CH_W];
            rsp_in.pixel_blue  = rdata_ff[0 +: CH_W];
         end else begin
            rsp_in.pixel_red   = '0;
            rsp_in.pixel_green = '0;
            rsp_in.pixel_blue  = '0;
         end
         rsp_in.pixels_touched = is_read ? '0 : touched_ff;
         rsp_in.outside_flag   = is_read ? rd_out_ff : reject_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
      end else begin
         addr_ff <= addr_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      c0_ff       <= c0_in;
      c_end_ff    <= c_end_in;
      r0_ff       <= r0_in;
      r_end_ff    <= r_end_in;
      reject_ff   <= reject_in;
      rd_out_ff   <= rd_out_in;
      row_base_ff <= row_base_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      touched_ff  <= touched_in;
      rsp_ff      <= rsp_in;
      fg_ff       <= fg_in;
      bg_ff       <= bg_in;
   end

   // frame store, one port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.mem_read) begin
         rdata_ff <= mem[addr_ff];
      end
   end

   assign stat_o.clear_last = (addr_ff == ADDR_W'(STORE_DEPTH - 1));
   assign stat_o.is_read    = is_read;
   assign stat_o.rd_outside = rd_out_ff;
   assign stat_o.reject     = reject_ff;
   assign stat_o.empty      = (c0_ff == c_end_ff) || (r0_ff == r_end_ff) ||
                              (req_ff.fill_alpha == ALPHA_CLEAR);
   assign stat_o.opaque     = (req_ff.fill_alpha == ALPHA_OPAQUE);
   assign stat_o.last_pixel = last_col && (row_nxt == r_end_ff);

   assign rsp_word = rsp_ff;

   `CRFB_ASSERT_NOW(a_write_in_store, clock, reset, mem_we, 32'(addr_ff) < STORE_DEPTH, "frame store write beyond depth")
   `CRFB_ASSERT_NOW(a_write_in_rect, clock, reset, advance, (col_ff < c_end_ff) && (row_ff < r_end_ff), "pixel write outside clipped rectangle")

endmodule

FILE: hw/rtl/crfb_ctrl.sv
// command sequencer for clear pass, read, fill and blend sweeps
`timescale 1ns / 1ps
`include "clipped_rect_fill_blend_assert.svh"
module crfb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  crfb_pkg::dp_stat_type stat_i,
   output crfb_pkg::dp_cmd_type  cmd_o
);
   import crfb_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd_o    = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd_o.clr_step = 1'b1;
            if (stat_i.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd_o.capture = 1'b1;
               state_in      = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd_o.setup = 1'b1;
            state_in    = ST_START;
         end
         ST_START: begin
            cmd_o.start = 1'b1;
            if (stat_i.is_read) begin
               state_in = stat_i.rd_outside ? ST_FINISH : ST_RD_ISSUE;
            end else if (stat_i.reject || stat_i.empty) begin
               state_in = ST_FINISH;
            end else if (stat_i.opaque) begin
               state_in = ST_FILL_WR;
            end else begin
               state_in = ST_BL_READ;
            end
         end
         ST_RD_ISSUE: begin
            cmd_o.mem_read = 1'b1;
            state_in       = ST_FINISH;
         end
         ST_FILL_WR: begin
            cmd_o.pix_write = 1'b1;
            if (stat_i.last_pixel) begin
               state_in = ST_FINISH;
            end
         end
         ST_BL_READ: begin
            cmd_o.mem_read = 1'b1;
            state_in       = ST_BL_MULT;
         end
         ST_BL_MULT: begin
            cmd_o.bl_mult = 1'b1;
            state_in      = ST_BL_WRITE;
         end
         ST_BL_WRITE: begin
            cmd_o.bl_write = 1'b1;
            state_in       = stat_i.last_pixel ? ST_FINISH : ST_BL_READ;
         end
         ST_FINISH: begin
            if (slot_free) begin
               cmd_o.rsp_load = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd_o.rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `CRFB_ASSERT_NEXT(a_accept_to_setup, clock, reset, req_valid && !req_stall, state_ff == ST_SETUP, "accepted word did not enter setup")
   `CRFB_ASSERT_NEXT(a_mult_then_write, clock, reset, cmd_o.bl_mult, cmd_o.bl_write, "blend products not written back")
   `CRFB_ASSERT_NOW(a_no_overwrite, clock, reset, cmd_o.rsp_load, slot_free, "pending result word overwritten")

endmodule
